// ===== design/e2q_pkg.sv =====
package e2q_pkg;

	localparam int ANGLE_WIDTH     = 16;
	localparam int OUT_WIDTH       = 16;
	localparam int TRIG_ITERATIONS = 16;

	// internal fixed point: 30 fraction bits
	localparam int QF = 30;
	localparam int CW = 34;
	localparam int TW = 32;

	localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;
	localparam int OUT_SHIFT   = 32 - OUT_WIDTH;

	// fold and rotation stages, negate stage, two product stages, sum, round
	localparam int STAGES      = TRIG_ITERATIONS + 6;
	localparam int NEG_STAGE   = TRIG_ITERATIONS + 1;
	localparam int COMB_FIRST  = TRIG_ITERATIONS + 2;

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [OUT_WIDTH-1:0]   quat_t;
	typedef logic signed [CW-1:0]          cw_t;
	typedef logic signed [TW-1:0]          trig_t;
	typedef logic signed [2*TW-1:0]        prod_t;
	typedef logic signed [TW:0]            sum_t;
	typedef logic signed [TW+1:0]          rnd_t;
	typedef logic [STAGES-1:0]             stage_en_t;

	localparam cw_t Q_HALF_PI = 34'sd1686629713;
	localparam cw_t Q_PI      = 34'sd3373259426;
	localparam cw_t Q_GAIN    = 34'sd652032874;

	localparam rnd_t OUT_LIM = rnd_t'(1) <<< (OUT_WIDTH - 2);
	localparam rnd_t OUT_RND = (OUT_SHIFT > 0) ? (rnd_t'(1) <<< (OUT_SHIFT - 1)) : rnd_t'(0);

	// arctangent of 2^-i in Q.30
	function automatic cw_t atan_at(input int idx);
		cw_t v;
		case (idx)
			0:  v = 34'sh03243F6A8;
			1:  v = 34'sh01DAC6705;
			2:  v = 34'sh00FADBAFC;
			3:  v = 34'sh007F56EA6;
			4:  v = 34'sh003FEAB76;
			5:  v = 34'sh001FFD55B;
			6:  v = 34'sh000FFFAAA;
			7:  v = 34'sh0007FFF55;
			8:  v = 34'sh0003FFFEA;
			9:  v = 34'sh0001FFFFD;
			10: v = 34'sh0000FFFFF;
			11: v = 34'sh00007FFFF;
			12: v = 34'sh00003FFFF;
			13: v = 34'sh00001FFFF;
			14: v = 34'sh00000FFFF;
			15: v = 34'sh000007FFF;
			16: v = 34'sh000003FFF;
			17: v = 34'sh000001FFF;
			18: v = 34'sh000000FFF;
			19: v = 34'sh0000007FF;
			20: v = 34'sh0000003FF;
			21: v = 34'sh0000001FF;
			22: v = 34'sh0000000FF;
			23: v = 34'sh00000007F;
			24: v = 34'sh00000003F;
			25: v = 34'sh00000001F;
			26: v = 34'sh00000000F;
			27: v = 34'sh000000008;
			28: v = 34'sh000000004;
			29: v = 34'sh000000002;
			30: v = 34'sh000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/e2q_ctrl.sv =====
module e2q_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_valid,
	output logic               angle_stall,
	output logic               quat_valid,
	input  logic               quat_stall,
	output e2q_pkg::stage_en_t en
);
	import e2q_pkg::*;

	stage_en_t valid_s;

	// a stage may load when some stage at or after it is empty, or the output drains
	always_comb begin
		for (int k = 0; k < STAGES; k++) begin
			en[k] = !(quat_stall && (&(valid_s | (stage_en_t'({STAGES{1'b1}}) >> (STAGES - k)))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= angle_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign angle_stall = !en[0];
	assign quat_valid  = valid_s[STAGES-1];

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> quat_stall && (&valid_s))
		else $error("input stalled while the pipeline has room");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && !angle_stall |=> valid_s[0])
		else $error("accepted request missing from first stage");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[STAGES-2] && !en[STAGES-2] |=> valid_s[STAGES-2])
		else $error("blocked stage dropped its request");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_stall && !valid_s[STAGES-2] |=> !quat_valid)
		else $error("delivered result repeated");

endmodule

// ===== design/e2q_cordic.sv =====
module e2q_cordic (
	input  logic               clk,
	input  e2q_pkg::stage_en_t en,
	input  e2q_pkg::angle_t    angle,
	output e2q_pkg::trig_t     cos_val,
	output e2q_pkg::trig_t     sin_val
);
	import e2q_pkg::*;

	cw_t   half;
	cw_t   fold;
	logic  flip;

	cw_t   x_s   [TRIG_ITERATIONS+1];
	cw_t   y_s   [TRIG_ITERATIONS+1];
	cw_t   z_s   [TRIG_ITERATIONS+1];
	logic  neg_s [TRIG_ITERATIONS+1];
	trig_t cos_s;
	trig_t sin_s;

	// fold the half angle into [-pi/2, pi/2], negate the results later
	always_comb begin
		half = cw_t'(angle) <<< ANGLE_SHIFT;
		fold = half;
		flip = 1'b0;
		if (half > Q_HALF_PI) begin
			fold = half - Q_PI;
			flip = 1'b1;
		end else if (half < -Q_HALF_PI) begin
			fold = half + Q_PI;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[0]   <= Q_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= fold;
			neg_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
		cw_t dx;
		cw_t dy;
		cw_t ang;

		assign dx  = y_s[i] >>> i;
		assign dy  = x_s[i] >>> i;
		assign ang = atan_at(i);

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ang;
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NEG_STAGE]) begin
			cos_s <= trig_t'(neg_s[TRIG_ITERATIONS] ? -x_s[TRIG_ITERATIONS] : x_s[TRIG_ITERATIONS]);
			sin_s <= trig_t'(neg_s[TRIG_ITERATIONS] ? -y_s[TRIG_ITERATIONS] : y_s[TRIG_ITERATIONS]);
		end
	end

	assign cos_val = cos_s;
	assign sin_val = sin_s;

endmodule

// ===== design/e2q_combine.sv =====
module e2q_combine (
	input  logic               clk,
	input  e2q_pkg::stage_en_t en,
	input  e2q_pkg::trig_t     cp,
	input  e2q_pkg::trig_t     sp,
	input  e2q_pkg::trig_t     cr,
	input  e2q_pkg::trig_t     sr,
	input  e2q_pkg::trig_t     cy,
	input  e2q_pkg::trig_t     sy,
	output e2q_pkg::quat_t     quat_w,
	output e2q_pkg::quat_t     quat_x,
	output e2q_pkg::quat_t     quat_y,
	output e2q_pkg::quat_t     quat_z
);
	import e2q_pkg::*;

	function automatic quat_t out_fix(input sum_t v);
		rnd_t r;
		r = (rnd_t'(v) + OUT_RND) >>> OUT_SHIFT;
		if (r > OUT_LIM) begin
			r = OUT_LIM;
		end else if (r < -OUT_LIM) begin
			r = -OUT_LIM;
		end
		return r[OUT_WIDTH-1:0];
	endfunction

	// local stage 1: yaw-roll pair products
	prod_t m_cycr, m_sysr, m_cysr, m_sycr;
	trig_t cycr_s1, sysr_s1, cysr_s1, sycr_s1, cp_s1, sp_s1;

	assign m_cycr = cy * cr;
	assign m_sysr = sy * sr;
	assign m_cysr = cy * sr;
	assign m_sycr = sy * cr;

	always_ff @(posedge clk) begin
		if (en[COMB_FIRST]) begin
			cycr_s1 <= m_cycr[QF +: TW];
			sysr_s1 <= m_sysr[QF +: TW];
			cysr_s1 <= m_cysr[QF +: TW];
			sycr_s1 <= m_sycr[QF +: TW];
			cp_s1   <= cp;
			sp_s1   <= sp;
		end
	end

	// local stage 2: triple products with pitch terms
	prod_t m_w1, m_w2, m_x1, m_x2, m_y1, m_y2, m_z1, m_z2;
	trig_t w1_s2, w2_s2, x1_s2, x2_s2, y1_s2, y2_s2, z1_s2, z2_s2;

	assign m_w1 = cycr_s1 * cp_s1;
	assign m_w2 = sysr_s1 * sp_s1;
	assign m_x1 = cysr_s1 * cp_s1;
	assign m_x2 = sycr_s1 * sp_s1;
	assign m_y1 = cycr_s1 * sp_s1;
	assign m_y2 = sysr_s1 * cp_s1;
	assign m_z1 = sycr_s1 * cp_s1;
	assign m_z2 = cysr_s1 * sp_s1;

	always_ff @(posedge clk) begin
		if (en[COMB_FIRST+1]) begin
			w1_s2 <= m_w1[QF +: TW];
			w2_s2 <= m_w2[QF +: TW];
			x1_s2 <= m_x1[QF +: TW];
			x2_s2 <= m_x2[QF +: TW];
			y1_s2 <= m_y1[QF +: TW];
			y2_s2 <= m_y2[QF +: TW];
			z1_s2 <= m_z1[QF +: TW];
			z2_s2 <= m_z2[QF +: TW];
		end
	end

	// local stage 3: component sums
	sum_t w_s3, x_s3, y_s3, z_s3;

	always_ff @(posedge clk) begin
		if (en[COMB_FIRST+2]) begin
			w_s3 <= sum_t'(w1_s2) + sum_t'(w2_s2);
			x_s3 <= sum_t'(x1_s2) - sum_t'(x2_s2);
			y_s3 <= sum_t'(y1_s2) + sum_t'(y2_s2);
			z_s3 <= sum_t'(z1_s2) - sum_t'(z2_s2);
		end
	end

	// local stage 4: round, clamp, hold as output
	quat_t w_s4, x_s4, y_s4, z_s4;

	always_ff @(posedge clk) begin
		if (en[COMB_FIRST+3]) begin
			w_s4 <= out_fix(w_s3);
			x_s4 <= out_fix(x_s3);
			y_s4 <= out_fix(y_s3);
			z_s4 <= out_fix(z_s3);
		end
	end

	assign quat_w = w_s4;
	assign quat_x = x_s4;
	assign quat_y = y_s4;
	assign quat_z = z_s4;

endmodule

// ===== design/euler_to_quaternion_top.sv =====
// Throughput: one request per cycle unless a stalled output fills the pipeline; each
// CORDIC rotation step has its own pipeline stage and each multiply its own multiplier,
// so no unit is shared between requests.
// A stalled output holds its stage; empty stages ahead of it keep accepting.
// Reset (arst_n low) clears all stage valid bits at once; data registers are not reset.
module euler_to_quaternion_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angle_valid,
	output logic            angle_stall,
	input  e2q_pkg::angle_t pitch_angle,
	input  e2q_pkg::angle_t roll_angle,
	input  e2q_pkg::angle_t yaw_angle,
	output logic            quat_valid,
	input  logic            quat_stall,
	output e2q_pkg::quat_t  quat_w,
	output e2q_pkg::quat_t  quat_x,
	output e2q_pkg::quat_t  quat_y,
	output e2q_pkg::quat_t  quat_z
);
	import e2q_pkg::*;

	stage_en_t en;
	trig_t     cp, sp, cr, sr, cy, sy;

	e2q_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.quat_valid  (quat_valid),
		.quat_stall  (quat_stall),
		.en          (en)
	);

	e2q_cordic u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   (pitch_angle),
		.cos_val (cp),
		.sin_val (sp)
	);

	e2q_cordic u_roll (
		.clk     (clk),
		.en      (en),
		.angle   (roll_angle),
		.cos_val (cr),
		.sin_val (sr)
	);

	e2q_cordic u_yaw (
		.clk     (clk),
		.en      (en),
		.angle   (yaw_angle),
		.cos_val (cy),
		.sin_val (sy)
	);

	e2q_combine u_combine (
		.clk    (clk),
		.en     (en),
		.cp     (cp),
		.sp     (sp),
		.cr     (cr),
		.sr     (sr),
		.cy     (cy),
		.sy     (sy),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z)
	);

endmodule

// ===== sim/euler_to_quaternion_tb.sv =====
`timescale 1ns / 100ps

module testbench;
	import e2q_pkg::*;

	localparam longint HALF_PI_Q30     = 64'sd1686629713;
	localparam longint PI_Q30          = 64'sd3373259426;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
	localparam int     FRAC_BITS       = 30;
	localparam int     FOLD_EDGE       = 25736;
	localparam int     HOLD_CYCLES     = 120;
	localparam int     SETTLE_CYCLES   = 30;

	typedef struct packed {
		quat_t w;
		quat_t x;
		quat_t y;
		quat_t z;
	} quat_rec_t;

	class quat_scoreboard;
		quat_rec_t expected_quats[$];
		longint    atan_q30[32];
		int        errors;

		function new();
			errors = 0;
			atan_q30 = '{
				'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
				'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
				'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
				'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
				'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
				'h00000001, 'h00000000
			};
		endfunction

		// cosine and sine of half the angle, Q.30
		function void half_angle_trig(input angle_t a, output longint c, output longint s);
			longint h;
			longint x;
			longint y;
			longint z;
			longint dx;
			longint dy;
			bit     flip;
			h = longint'(a) * (longint'(1) << (32 - ANGLE_WIDTH));
			flip = 1'b0;
			// fold into +-pi/2, negate the results afterwards
			if (h > HALF_PI_Q30) begin
				h = h - PI_Q30;
				flip = 1'b1;
			end else if (h < -HALF_PI_Q30) begin
				h = h + PI_Q30;
				flip = 1'b1;
			end
			x = CORDIC_GAIN_Q30;
			y = 0;
			z = h;
			for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atan_q30[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atan_q30[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint triple_product(longint a, longint b, longint c);
			return (((a * b) >>> FRAC_BITS) * c) >>> FRAC_BITS;
		endfunction

		function quat_t round_saturate(longint v);
			longint lim;
			int     sh;
			lim = longint'(1) << (OUT_WIDTH - 2);
			sh  = 32 - OUT_WIDTH;
			if (sh > 0)
				v = (v + (longint'(1) << (sh - 1))) >>> sh;
			if (v > lim)
				v = lim;
			if (v < -lim)
				v = -lim;
			return quat_t'(v);
		endfunction

		function quat_rec_t compute_quaternion(angle_t pitch, angle_t roll, angle_t yaw);
			longint    cp;
			longint    sp;
			longint    cr;
			longint    sr;
			longint    cy;
			longint    sy;
			quat_rec_t q;
			half_angle_trig(pitch, cp, sp);
			half_angle_trig(roll, cr, sr);
			half_angle_trig(yaw, cy, sy);
			q.w = round_saturate(triple_product(cy, cr, cp) + triple_product(sy, sr, sp));
			q.x = round_saturate(triple_product(cy, sr, cp) - triple_product(sy, cr, sp));
			q.y = round_saturate(triple_product(cy, cr, sp) + triple_product(sy, sr, cp));
			q.z = round_saturate(triple_product(sy, cr, cp) - triple_product(cy, sr, sp));
			return q;
		endfunction

		function void note_request(angle_t pitch, angle_t roll, angle_t yaw);
			expected_quats.push_back(compute_quaternion(pitch, roll, yaw));
		endfunction

		function void check_result(quat_t w, quat_t x, quat_t y, quat_t z);
			quat_rec_t q;
			if (expected_quats.size() == 0) begin
				$error("quaternion result with no request pending: w=%0d x=%0d y=%0d z=%0d",
					w, x, y, z);
				errors++;
				return;
			end
			q = expected_quats.pop_front();
			if (w !== q.w) begin
				$error("quat_w: expected %0d, actual %0d", q.w, w);
				errors++;
			end
			if (x !== q.x) begin
				$error("quat_x: expected %0d, actual %0d", q.x, x);
				errors++;
			end
			if (y !== q.y) begin
				$error("quat_y: expected %0d, actual %0d", q.y, y);
				errors++;
			end
			if (z !== q.z) begin
				$error("quat_z: expected %0d, actual %0d", q.z, z);
				errors++;
			end
		endfunction

		function int pending();
			return expected_quats.size();
		endfunction
	endclass

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   angle_valid = 1'b0;
	logic   angle_stall;
	angle_t pitch_angle = '0;
	angle_t roll_angle  = '0;
	angle_t yaw_angle   = '0;
	logic   quat_valid;
	logic   quat_stall  = 1'b0;
	quat_t  quat_w;
	quat_t  quat_x;
	quat_t  quat_y;
	quat_t  quat_z;

	bit     hold_req       = 1'b0;
	int     recv_stall_pct = 0;

	quat_scoreboard sb;

	euler_to_quaternion_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.pitch_angle (pitch_angle),
		.roll_angle  (roll_angle),
		.yaw_angle   (yaw_angle),
		.quat_valid  (quat_valid),
		.quat_stall  (quat_stall),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				quat_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				quat_stall <= 1'b1;
				hold_req <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
			end else begin
				quat_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// inputs change only at rising edges, so values at the falling edge are the ones sampled
	always @(negedge clk) begin
		if (arst_n && quat_valid && !quat_stall)
			sb.check_result(quat_w, quat_x, quat_y, quat_z);
	end

	function automatic angle_t random_angle();
		angle_t v;
		case ($urandom_range(9))
			0: begin
				v = angle_t'(FOLD_EDGE - 3 + $urandom_range(6));
				if ($urandom_range(1))
					v = -v;
			end
			1: v = $urandom_range(1) ? angle_t'(32767 - $urandom_range(15))
				: angle_t'(-32768 + int'($urandom_range(15)));
			2: v = angle_t'(int'($urandom_range(64)) - 32);
			default: v = angle_t'($urandom());
		endcase
		return v;
	endfunction

	task automatic send_request(input angle_t p, input angle_t r, input angle_t y);
		logic took;
		pitch_angle <= p;
		roll_angle  <= r;
		yaw_angle   <= y;
		angle_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = !angle_stall;
			@(posedge clk);
		end while (!took);
		sb.note_request(p, r, y);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			angle_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
	endtask

	// lower valid and hold until every request has come back
	task automatic drain();
		angle_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count, input int idle_pct);
		for (int n = 0; n < count; n++) begin
			sender_gap(idle_pct);
			send_request(random_angle(), random_angle(), random_angle());
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, fold boundaries, quarter turns, near zero
		send_request(0, 0, 0);
		send_request(32767, 32767, 32767);
		send_request(-32768, -32768, -32768);
		send_request(32767, 0, 0);
		send_request(0, 32767, 0);
		send_request(0, 0, 32767);
		send_request(-32768, 0, 0);
		send_request(0, -32768, 0);
		send_request(0, 0, -32768);
		send_request(25735, 25736, -25736);
		send_request(-25735, -25737, 25737);
		send_request(25736, 25736, 25736);
		send_request(12868, 0, 0);
		send_request(0, 12868, 0);
		send_request(0, 0, 12868);
		send_request(-12868, -12868, -12868);
		send_request(1, -1, 1);
		send_request(-1, 1, -1);
		send_request(32767, -32768, 32767);
		send_request(-32768, 32767, -32768);
		drain();

		recv_stall_pct = 62;
		run_random(470, 36);
		drain();

		recv_stall_pct = 36;
		run_random(470, 62);
		drain();

		// long receiver hold-off while requests keep coming: fill the pipeline
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		run_random(490, 0);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("euler_to_quaternion_top test passed");
		end else begin
			$display("euler_to_quaternion_top test failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("euler_to_quaternion_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/e2q_pkg.sv
design/e2q_ctrl.sv
design/e2q_cordic.sv
design/e2q_combine.sv
design/euler_to_quaternion_top.sv
sim/euler_to_quaternion_tb.sv
